// ===== hw/rtl/sync_length_crc8_deframer_unit_macros.svh =====
// assertion macros shared by the deframer rtl
// needs signals named clock and reset in the module that uses them
`ifndef SYNC_LENGTH_CRC8_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_LENGTH_CRC8_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define SLCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define SLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/slcd_pkg.sv =====
// shared constants and types of the sync / length / crc-8 deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

   localparam logic [7:0] SYNC_HI  = 8'h24;
   localparam logic [7:0] SYNC_LO  = 8'h40;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h07;

   localparam int WIN_LEN   = 12;
   localparam int HDR_LEN   = 8;
   localparam int BUF_BYTES = 4096;

   localparam int FILL_W = 4;
   localparam int IDX_W  = 3;
   localparam int LEFT_W = 16;
   localparam int PLEN_W = 12;
   localparam int TS_W   = 64;

   localparam int REQ_W = 72;
   localparam int RSP_W = 144;

   // command to the crc unit
   typedef struct packed {
      logic       init;
      logic       step;
      logic [7:0] data;
   } crc_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sync_length_crc8_deframer_unit.sv =====
// top level of the sync / length / crc-8 deframer
// depends on slcd_pkg, slcd_crc8 and sync_length_crc8_deframer_unit_macros.svh
//
// channel  dir  width  contents (lowest bits first)
// req_     in   72     tdata: rx_byte[7:0], time_stamp[71:8]
// rsp_     out  144    tdata: version, sequence, msg type, payload length,
//                      payload byte, echo time, zero fill; tuser: kind; tlast
//
// hunting bytes are taken whenever offered; a payload byte waits only
// for the single output register to drain
// a complete 12-byte window runs its 8 header bytes through the crc unit,
// one header byte per cycle, then moves to a check state, where a passing
// header waits for the output register
// a rejected window drops its sync byte in the check state, then rescans,
// shifting out one byte per cycle until the window is empty or opens with
// sync high (then sync low, if present), with req_tready low throughout
// reset (synchronous, active high) empties the window and returns to hunting
`timescale 1ns / 1ps
`default_nettype none

`include "sync_length_crc8_deframer_unit_macros.svh"

module sync_length_crc8_deframer_unit
   import slcd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // input byte stream
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // rx_byte[7:0], time_stamp[71:8]
   // result stream
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // hdr_version[7:0], hdr_sequence[23:8],
                                              // hdr_msg_type[55:24],
                                              // payload_length[67:56],
                                              // payload_byte[75:68],
                                              // echo_time[139:76], zero[143:140]
   output logic [0:0]            rsp_tuser,   // result_kind[0]: 0 header, 1 payload
   output logic                  rsp_tlast    // last_of_frame
);

   // sequencer states
   localparam logic [2:0] ST_HUNT    = 3'd0;
   localparam logic [2:0] ST_CRC     = 3'd1;
   localparam logic [2:0] ST_CHECK   = 3'd2;
   localparam logic [2:0] ST_RESCAN  = 3'd3;
   localparam logic [2:0] ST_PAYLOAD = 3'd4;

   localparam int HDR_FLD_W = 8 + 16 + 32 + PLEN_W;

   // sequencer and window state
   logic [2:0]        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [7:0]        win_ff [WIN_LEN];
   logic [7:0]        win_in [WIN_LEN];
   logic [TS_W-1:0]   ts_ff, ts_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic              rsp_last_ff, rsp_last_in;

   // datapath signals
   logic [7:0]        rx_byte;
   logic [TS_W-1:0]   time_stamp;
   logic              req_acc;
   logic              out_free;
   logic [15:0]       frame_len;
   logic [LEFT_W-1:0] pay_len;
   logic              len_ok;
   logic              hdr_pass;
   logic              hdr_load;
   logic [7:0]        crc_byte;
   logic [7:0]        crc_value;
   logic [LEFT_W-1:0] left_dec;
   logic [HDR_FLD_W-1:0] hdr_fields;
   crc_ctrl_type      crc_ctrl;

   assign rx_byte    = req_tdata[7:0];
   assign time_stamp = req_tdata[71:8];

   // output slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_HUNT) || ((state_ff == ST_PAYLOAD) && out_free);
   assign req_acc    = req_tvalid && req_tready;

   // header checks on the full window
   assign frame_len = {win_ff[2], win_ff[3]};
   assign pay_len   = frame_len - LEFT_W'(HDR_LEN);
   assign len_ok    = (frame_len >= 16'(HDR_LEN)) &&
                      (({1'b0, frame_len} + 17'd4) <= 17'(BUF_BYTES));
   assign hdr_pass  = len_ok && (crc_value == win_ff[5]);
   assign hdr_load  = (state_ff == ST_CHECK) && hdr_pass && out_free;

   // header byte for this crc pass, crc byte itself counted as zero
   assign crc_byte  = (idx_ff == IDX_W'(1)) ? 8'h00 : win_ff[FILL_W'(4) + FILL_W'(idx_ff)];
   assign left_dec  = left_ff - LEFT_W'(1);

   assign hdr_fields = {pay_len[PLEN_W-1:0],
                        win_ff[8], win_ff[9], win_ff[10], win_ff[11],
                        win_ff[6], win_ff[7],
                        win_ff[4]};

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      win_in       = win_ff;
      ts_in        = ts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      crc_ctrl     = '0;
      crc_ctrl.data = crc_byte;

      case (state_ff)
         ST_HUNT: begin
            if (req_acc) begin
               if (fill_ff == '0) begin
                  // only a sync high byte may open the window
                  if (rx_byte == SYNC_HI) begin
                     win_in[0] = rx_byte;
                     fill_in   = FILL_W'(1);
                  end
               end else if (fill_ff == FILL_W'(1)) begin
                  if (rx_byte == SYNC_LO) begin
                     win_in[1] = rx_byte;
                     fill_in   = FILL_W'(2);
                  end else if (rx_byte != SYNC_HI) begin
                     fill_in   = '0;
                  end
               end else begin
                  win_in[fill_ff] = rx_byte;
                  fill_in         = fill_ff + FILL_W'(1);
                  if (fill_ff == FILL_W'(WIN_LEN - 1)) begin
                     // window complete: start the crc pass
                     ts_in         = time_stamp;
                     idx_in        = '0;
                     crc_ctrl.init = 1'b1;
                     state_in      = ST_CRC;
                  end
               end
            end
         end
         ST_CRC: begin
            crc_ctrl.step = 1'b1;
            idx_in        = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(HDR_LEN - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!hdr_pass) begin
               // reject: drop the sync byte and rescan the rest
               for (int k = 0; k < WIN_LEN - 1; k++) begin
                  win_in[k] = win_ff[k + 1];
               end
               fill_in  = fill_ff - FILL_W'(1);
               state_in = ST_RESCAN;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b0;
               rsp_last_in  = (pay_len == '0);
               rsp_data_in  = {4'h0, ts_ff, 8'h00, hdr_fields};
               fill_in      = '0;
               left_in      = pay_len;
               state_in     = (pay_len == '0) ? ST_HUNT : ST_PAYLOAD;
            end
         end
         ST_RESCAN: begin
            if ((fill_ff == '0) ||
                ((win_ff[0] == SYNC_HI) &&
                 ((fill_ff < FILL_W'(2)) || (win_ff[1] == SYNC_LO)))) begin
               state_in = ST_HUNT;
            end else begin
               for (int k = 0; k < WIN_LEN - 1; k++) begin
                  win_in[k] = win_ff[k + 1];
               end
               fill_in = fill_ff - FILL_W'(1);
            end
         end
         ST_PAYLOAD: begin
            if (req_acc) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b1;
               rsp_last_in  = (left_dec == '0);
               rsp_data_in  = {4'h0, time_stamp, rx_byte, HDR_FLD_W'(0)};
               left_in      = left_dec;
               if (left_dec == '0) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
            fill_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         fill_ff      <= '0;
         idx_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // window and result payload carry no reset
   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      ts_ff       <= ts_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   slcd_crc8 u_crc (
      .clock     (clock),
      .reset     (reset),
      .crc_ctrl  (crc_ctrl),
      .crc_value (crc_value)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_kind_ff;
   assign rsp_tlast    = rsp_last_ff;

   // window alignment while hunting
   `SLCD_ASSERT_IMPLY(a_hunt_sync_hi, (state_ff == ST_HUNT) && (fill_ff != '0),
                      win_ff[0] == SYNC_HI, "hunt window does not open with sync high")
   `SLCD_ASSERT_IMPLY(a_hunt_sync_lo, (state_ff == ST_HUNT) && (fill_ff >= FILL_W'(2)),
                      win_ff[1] == SYNC_LO, "hunt window lacks sync low")
   // crc pass only runs over a full window
   `SLCD_ASSERT_IMPLY(a_crc_full, state_ff == ST_CRC, fill_ff == FILL_W'(WIN_LEN),
                      "crc pass on partial window")
   // accepted header empties the window
   `SLCD_ASSERT_NEXT(a_hdr_clear, hdr_load,
                     (fill_ff == '0) && rsp_valid_ff && !rsp_kind_ff,
                     "header transaction did not reset window")
   // final payload byte returns to hunting
   `SLCD_ASSERT_NEXT(a_last_hunt,
                     req_acc && (state_ff == ST_PAYLOAD) && (left_ff == LEFT_W'(1)),
                     (state_ff == ST_HUNT) && rsp_tlast, "frame end not followed by hunt")

endmodule

`default_nettype wire

// ===== hw/rtl/slcd_crc8.sv =====
// crc-8 accumulator, polynomial 0x07, msb first, one byte per step
// depends on slcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module slcd_crc8
   import slcd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire crc_ctrl_type crc_ctrl,
   output logic [7:0]        crc_value
);

   logic [7:0] acc_ff;
   logic [7:0] acc_in;

   function automatic logic [7:0] crc_byte_step(input logic [7:0] acc, input logic [7:0] din);
      logic [7:0] a;
      a = acc ^ din;
      for (int b = 0; b < 8; b++) begin
         if (a[7]) begin
            a = {a[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            a = {a[6:0], 1'b0};
         end
      end
      return a;
   endfunction

   always_comb begin
      acc_in = acc_ff;
      if (reset || crc_ctrl.init) begin
         acc_in = CRC_INIT;
      end else if (crc_ctrl.step) begin
         acc_in = crc_byte_step(acc_ff, crc_ctrl.data);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign crc_value = acc_ff;

endmodule

`default_nettype wire

// ===== bench/sync_length_crc8_deframer_unit_tb.sv =====
// self-checking testbench for the sync / length / crc-8 deframer
// depends on slcd_pkg and sync_length_crc8_deframer_unit (with its crc unit)
// a local deframer predicts every result; a checker matches them in order
`timescale 1ns / 1ps

module sync_length_crc8_deframer_unit_tb;
   import slcd_pkg::*;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // no transaction for this many cycles ends the run; the slowest legal gap is
   // the receiver hold-off of test_output_stall plus crc and rescan time of one window
   localparam int QUIET_LIMIT = 5000;
   // crc pass plus the longest rescan, with margin
   localparam int TAIL_CYCLES = 40;

   typedef struct packed {
      logic              kind;
      logic [7:0]        version;
      logic [15:0]       sequence_num;
      logic [31:0]       msg_type;
      logic [PLEN_W-1:0] plen;
      logic [7:0]        pbyte;
      logic              last;
      logic [TS_W-1:0]   echo;
   } frame_result_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;  // rx_byte[7:0], time_stamp[71:8]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // hdr_version[7:0], hdr_sequence[23:8],
                                       // hdr_msg_type[55:24], payload_length[67:56],
                                       // payload_byte[75:68], echo_time[139:76]
   logic [0:0]       rsp_tuser;        // result_kind[0]
   logic             rsp_tlast;        // last_of_frame

   // predictor state
   logic [7:0]    hunt_window [WIN_LEN];
   int unsigned   hunt_fill     = 0;
   logic [15:0]   bytes_to_pass = '0;
   logic          passing       = 1'b0;
   frame_result_type pending_results [$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int stall_request  = 0;
   int stall_left     = 0;
   int quiet_cycles   = 0;

   sync_length_crc8_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // crc-8 over the 8 header bytes, version in the top byte, crc byte taken as zero
   function automatic logic [7:0] header_crc(input logic [63:0] hdr);
      logic [7:0] acc;
      logic [7:0] v;
      int         i;
      int         b;
      acc = CRC_INIT;
      for (i = 0; i < HDR_LEN; i++) begin
         v = (i == 1) ? 8'h00 : hdr[63 - 8 * i -: 8];
         acc = acc ^ v;
         for (b = 0; b < 8; b++) begin
            acc = acc[7] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
         end
      end
      return acc;
   endfunction

   // drop bytes ahead of start and any that cannot begin a sync pair
   function automatic void realign_window(input int unsigned start);
      int unsigned s;
      int unsigned k;
      s = start;
      while (s < hunt_fill && !(hunt_window[s] == SYNC_HI &&
             (s + 1 >= hunt_fill || hunt_window[s + 1] == SYNC_LO)))
         s++;
      if (s >= hunt_fill) begin
         hunt_fill = 0;
      end else begin
         for (k = 0; s + k < hunt_fill; k++)
            hunt_window[k] = hunt_window[s + k];
         hunt_fill = hunt_fill - s;
      end
   endfunction

   // expected deframer behavior for one accepted stream byte
   task automatic deframe_byte(input logic [7:0] b, input logic [63:0] ts);
      frame_result_type r;
      logic [31:0]   flen;
      logic [63:0]   hdr;
      r = '0;
      r.echo = ts;
      if (passing) begin
         bytes_to_pass = bytes_to_pass - 16'd1;
         r.kind  = KIND_PAYLOAD;
         r.pbyte = b;
         r.last  = (bytes_to_pass == 16'd0);
         if (bytes_to_pass == 16'd0)
            passing = 1'b0;
         pending_results.push_back(r);
      end else begin
         if (hunt_fill >= WIN_LEN)
            hunt_fill = 0;
         hunt_window[hunt_fill] = b;
         hunt_fill++;
         realign_window(0);
         if (hunt_fill == WIN_LEN) begin
            flen = {16'h0000, hunt_window[2], hunt_window[3]};
            hdr  = {hunt_window[4], hunt_window[5], hunt_window[6], hunt_window[7],
                    hunt_window[8], hunt_window[9], hunt_window[10], hunt_window[11]};
            if (flen < HDR_LEN || flen + 4 > BUF_BYTES ||
                header_crc(hdr) != hunt_window[5]) begin
               // rejected candidate: rescan from one past the sync byte
               realign_window(1);
            end else begin
               r.kind         = KIND_HEADER;
               r.version      = hunt_window[4];
               r.sequence_num = {hunt_window[6], hunt_window[7]};
               r.msg_type     = hdr[31:0];
               r.plen         = flen[11:0] - 12'd8;
               r.last         = (flen == HDR_LEN);
               pending_results.push_back(r);
               hunt_fill     = 0;
               bytes_to_pass = flen[15:0] - 16'd8;
               passing       = (bytes_to_pass != 16'd0);
            end
         end
      end
   endtask

   function automatic logic [63:0] next_stamp();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return {$urandom, $urandom};
   endfunction

   // stream bytes leaning toward the sync values
   function automatic logic [7:0] pick_stream_byte();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)
         return SYNC_HI;
      if (pick < 40)
         return SYNC_LO;
      return 8'($urandom);
   endfunction

   // offer one byte and wait for its transaction; tvalid stays high afterwards
   task automatic send_byte(input logic [7:0] b);
      logic [63:0] ts;
      ts = next_stamp();
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ts, b};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      deframe_byte(b, ts);
      items_sent++;
   endtask

   task automatic send_frame(input logic [15:0] flen, input logic [7:0] ver,
                             input logic [15:0] seqn, input logic [31:0] mtype,
                             input int n_pay, input logic bad_crc);
      logic [63:0] hdr;
      logic [7:0]  crc;
      int          i;
      hdr = {ver, 8'h00, seqn, mtype};
      crc = header_crc(hdr);
      if (bad_crc)
         crc = crc ^ (8'h01 << $urandom_range(0, 7));
      hdr[55:48] = crc;
      send_byte(SYNC_HI);
      send_byte(SYNC_LO);
      send_byte(flen[15:8]);
      send_byte(flen[7:0]);
      for (i = 0; i < HDR_LEN; i++)
         send_byte(hdr[63 - 8 * i -: 8]);
      for (i = 0; i < n_pay; i++)
         send_byte(pick_stream_byte());
   endtask

   // sender pauses until every predicted result has come out
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_payload();
      send_frame(16'd8, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 1'b0);
      send_frame(16'd8, 8'h00, 16'h0000, 32'h0000_0000, 0, 1'b0);
   endtask

   // sync bytes inside the payload must pass through untouched
   task automatic test_sync_in_payload();
      send_frame(16'd12, 8'($urandom), 16'($urandom), $urandom, 0, 1'b0);
      send_byte(SYNC_HI);
      send_byte(SYNC_LO);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_short_length();
      send_frame(16'd0, 8'($urandom), 16'($urandom), $urandom, 0, 1'b0);
      send_frame(16'd7, 8'($urandom), 16'($urandom), $urandom, 0, 1'b0);
      send_frame(16'd9, 8'($urandom), 16'($urandom), $urandom, 1, 1'b0);
   endtask

   task automatic test_oversized_length();
      send_frame(16'(BUF_BYTES - 3), 8'($urandom), 16'($urandom), $urandom, 0, 1'b0);
      send_frame(16'hFFFF, 8'($urandom), 16'($urandom), $urandom, 0, 1'b0);
      send_frame(16'd10, 8'($urandom), 16'($urandom), $urandom, 2, 1'b0);
   endtask

   task automatic test_crc_mismatch();
      send_frame(16'd10, 8'($urandom), 16'($urandom), $urandom, 0, 1'b1);
      send_frame(16'd10, 8'($urandom), 16'($urandom), $urandom, 2, 1'b0);
   endtask

   // stray bytes, a doubled sync byte and a candidate whose length bytes are
   // a sync pair, so the rescan has to find the real frame inside the window
   task automatic test_hunting();
      send_byte(SYNC_LO);
      send_byte(SYNC_HI);
      send_byte(SYNC_HI);
      send_byte(SYNC_LO);
      send_frame(16'd11, 8'($urandom), 16'($urandom), $urandom, 3, 1'b0);
   endtask

   // largest accepted length; only the first payload bytes are sent, so this
   // runs last and leaves the frame open
   task automatic test_max_length();
      send_frame(16'(BUF_BYTES - 4), 8'($urandom), 16'($urandom), $urandom, 8, 1'b0);
   endtask

   // receiver holds off while frames keep coming, so the input has to stall
   task automatic test_output_stall();
      stall_request = 300;
      repeat (4)
         send_frame(16'd48, 8'($urandom), 16'($urandom), $urandom, 40, 1'b0);
   endtask

   task automatic test_drain_pause();
      send_frame(16'd20, 8'($urandom), 16'($urandom), $urandom, 12, 1'b0);
      wait_for_drain();
      send_frame(16'd8, 8'($urandom), 16'($urandom), $urandom, 0, 1'b0);
   endtask

   // mostly well-formed frames with random content, the rest broken or noise
   task automatic run_random_traffic(input int target);
      int          start;
      int          pick;
      int          n_pay;
      logic [15:0] flen;
      start = items_sent;
      while (items_sent - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            n_pay = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(0, 24);
            flen = 16'(n_pay + HDR_LEN);
            send_frame(flen, 8'($urandom), 16'($urandom), $urandom, n_pay, 1'b0);
         end else if (pick < 70) begin
            send_frame(16'($urandom_range(8, 32)), 8'($urandom), 16'($urandom),
                       $urandom, 0, 1'b1);
         end else if (pick < 78) begin
            send_frame(16'($urandom_range(0, 7)), 8'($urandom), 16'($urandom),
                       $urandom, 0, 1'b0);
         end else if (pick < 84) begin
            send_frame(16'($urandom_range(BUF_BYTES - 3, 65535)), 8'($urandom),
                       16'($urandom), $urandom, 0, 1'b0);
         end else begin
            repeat ($urandom_range(1, 6))
               send_byte(pick_stream_byte());
         end
      end
   endtask

   // receiver side: random idling plus requested long hold-offs
   always @(posedge clock) begin
      if (stall_request > 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(input string fname, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
         mismatch_count++;
      end
   endfunction

   // every result transaction is matched against the oldest prediction
   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h %h %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", 64'(want.kind), 64'(rsp_tuser[0]));
            check_field("hdr_version", 64'(want.version), 64'(rsp_tdata[7:0]));
            check_field("hdr_sequence", 64'(want.sequence_num), 64'(rsp_tdata[23:8]));
            check_field("hdr_msg_type", 64'(want.msg_type), 64'(rsp_tdata[55:24]));
            check_field("payload_length", 64'(want.plen), 64'(rsp_tdata[67:56]));
            check_field("payload_byte", 64'(want.pbyte), 64'(rsp_tdata[75:68]));
            check_field("last_of_frame", 64'(want.last), 64'(rsp_tlast));
            check_field("echo_time", want.echo, rsp_tdata[139:76]);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("sync_length_crc8_deframer_unit_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 12;
      recv_idle_pct = 56;
      test_empty_payload();
      test_sync_in_payload();
      test_short_length();
      test_oversized_length();
      test_crc_mismatch();
      test_hunting();
      test_output_stall();
      test_drain_pause();
      run_random_traffic(290);
      wait_for_drain();

      send_idle_pct = 56;
      recv_idle_pct = 12;
      run_random_traffic(290);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_traffic(290);
      wait_for_drain();

      test_max_length();
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: results missing: expected %0d more, actual 0",
                  $time, pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("sync_length_crc8_deframer_unit_tb passed");
      end else begin
         $display("sync_length_crc8_deframer_unit_tb failed");
      end
      $finish;
   end

endmodule
